@@ design/swfp_pkg.sv @@
// Shared constants, register codes and pipeline control type of the
// swing foot trajectory sampler. No dependencies.
`timescale 1ns / 1ps

package swfp_pkg;

    localparam int INDEX_BITS = 12;
    localparam int FRAC_BITS  = 16;
    localparam int UNIT_BITS  = 30;
    localparam int TIME_BITS  = 31;
    localparam int VALUE_BITS = 32;
    localparam int PROD_BITS  = INDEX_BITS + TIME_BITS;
    localparam int IN_TDATA_W = ((INDEX_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = 2 * VALUE_BITS;
    localparam int CFG_ADDR_W = 2;

    localparam logic [TIME_BITS-1:0]  TIME_RESET = TIME_BITS'(64'd1 << FRAC_BITS);
    localparam logic [UNIT_BITS:0]    UNIT_ONE   = {1'b1, {UNIT_BITS{1'b0}}};
    localparam logic [UNIT_BITS+1:0]  UNIT_THREE = {2'b11, {UNIT_BITS{1'b0}}};

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_SAMPLE_PERIOD = 2'd0,
        REG_SWING_TIME    = 2'd1,
        REG_STEP_LENGTH   = 2'd2,
        REG_STEP_HEIGHT   = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic valid;
        logic swing;
    } t_ctl;

endpackage

@@ design/swfp_div.sv @@
// Pipelined restoring divider: normalized time u = floor(t * 2^30 / T),
// one quotient bit per stage. Depends on swfp_pkg.
`timescale 1ns / 1ps

module swfp_div
    import swfp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic [TIME_BITS-1:0] i_swing_time,
    input  t_ctl                 i_ctl,
    input  logic [TIME_BITS-1:0] i_rem,
    output t_ctl                 o_ctl,
    output logic [UNIT_BITS-1:0] o_quot
);

    t_ctl                 r_ctl [UNIT_BITS];
    logic [TIME_BITS-1:0] r_rem [UNIT_BITS];
    logic [UNIT_BITS-1:0] r_q   [UNIT_BITS];

    for (genvar k = 0; k < UNIT_BITS; k++) begin : g_step
        t_ctl                 ctl_in;
        logic [TIME_BITS-1:0] rem_in;
        logic [UNIT_BITS-1:0] q_in;
        logic [TIME_BITS:0]   shifted;
        logic [TIME_BITS+1:0] diff;

        if (k == 0) begin : g_first
            assign ctl_in = i_ctl;
            assign rem_in = i_rem;
            assign q_in   = '0;
        end else begin : g_next
            assign ctl_in = r_ctl[k-1];
            assign rem_in = r_rem[k-1];
            assign q_in   = r_q[k-1];
        end

        assign shifted = {rem_in, 1'b0};
        assign diff    = {1'b0, shifted} - {2'b00, i_swing_time};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[k] <= '0;
            end else if (i_en) begin
                r_ctl[k] <= ctl_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!diff[TIME_BITS+1]) begin
                    r_rem[k] <= diff[TIME_BITS-1:0];
                end else begin
                    r_rem[k] <= shifted[TIME_BITS-1:0];
                end
                r_q[k] <= {q_in[UNIT_BITS-2:0], ~diff[TIME_BITS+1]};
            end
        end
    end

    assign o_ctl  = r_ctl[UNIT_BITS-1];
    assign o_quot = r_q[UNIT_BITS-1];

endmodule

@@ design/swfp_shape.sv @@
// Shape polynomials and scaling: forward and vertical shape from u, then
// step length and height scaled toward zero. Depends on swfp_pkg.
`timescale 1ns / 1ps

module swfp_shape
    import swfp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic [VALUE_BITS-1:0] i_step_length,
    input  logic [VALUE_BITS-1:0] i_step_height,
    input  t_ctl                  i_ctl,
    input  logic [UNIT_BITS-1:0]  i_u,
    output t_ctl                  o_ctl,
    output logic [VALUE_BITS-1:0] o_forward,
    output logic [VALUE_BITS-1:0] o_height
);

    // stage 1: u^2, u*(1-u), 3 - 2u
    t_ctl                  r_ctl1;
    logic [UNIT_BITS-1:0]  r_u2;
    logic [UNIT_BITS-2:0]  r_v;
    logic [UNIT_BITS+1:0]  r_w;
    logic [2*UNIT_BITS-1:0] n_u2_full;
    logic [2*UNIT_BITS:0]   n_v_full;

    assign n_u2_full = (2*UNIT_BITS)'(i_u) * (2*UNIT_BITS)'(i_u);
    assign n_v_full  = (2*UNIT_BITS+1)'(i_u) * (2*UNIT_BITS+1)'(UNIT_ONE - {1'b0, i_u});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
        end else if (i_en) begin
            r_ctl1 <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_u2 <= n_u2_full[2*UNIT_BITS-1:UNIT_BITS];
            r_v  <= n_v_full[2*UNIT_BITS-2:UNIT_BITS];
            r_w  <= UNIT_THREE - {1'b0, i_u, 1'b0};
        end
    end

    // stage 2: f and g, resting phase forces f = 1.0, g = 0
    t_ctl                  r_ctl2;
    logic [UNIT_BITS:0]    r_f;
    logic [UNIT_BITS:0]    r_g;
    logic [2*UNIT_BITS+1:0] n_f_full;
    logic [2*UNIT_BITS-3:0] n_g_full;

    assign n_f_full = (2*UNIT_BITS+2)'(r_u2) * (2*UNIT_BITS+2)'(r_w);
    assign n_g_full = (2*UNIT_BITS-2)'(r_v) * (2*UNIT_BITS-2)'(r_v);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl2 <= '0;
        end else if (i_en) begin
            r_ctl2 <= r_ctl1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_ctl1.swing) begin
                r_f <= n_f_full[2*UNIT_BITS:UNIT_BITS];
                r_g <= n_g_full[2*UNIT_BITS-4:UNIT_BITS-4];
            end else begin
                r_f <= UNIT_ONE;
                r_g <= '0;
            end
        end
    end

    // stage 3: magnitude times shape
    t_ctl                  r_ctl3;
    logic [VALUE_BITS-1:0] r_fwd_mag;
    logic [VALUE_BITS-1:0] r_hgt_mag;
    logic [VALUE_BITS-1:0] n_len_mag;
    logic [VALUE_BITS-1:0] n_hgt_mag;
    logic [VALUE_BITS+UNIT_BITS:0] n_fwd_prod;
    logic [VALUE_BITS+UNIT_BITS:0] n_hgt_prod;

    assign n_len_mag  = i_step_length[VALUE_BITS-1] ? -i_step_length : i_step_length;
    assign n_hgt_mag  = i_step_height[VALUE_BITS-1] ? -i_step_height : i_step_height;
    assign n_fwd_prod = (VALUE_BITS+UNIT_BITS+1)'(n_len_mag) * (VALUE_BITS+UNIT_BITS+1)'(r_f);
    assign n_hgt_prod = (VALUE_BITS+UNIT_BITS+1)'(n_hgt_mag) * (VALUE_BITS+UNIT_BITS+1)'(r_g);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl3 <= '0;
        end else if (i_en) begin
            r_ctl3 <= r_ctl2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_fwd_mag <= n_fwd_prod[VALUE_BITS+UNIT_BITS-1:UNIT_BITS];
            r_hgt_mag <= n_hgt_prod[VALUE_BITS+UNIT_BITS-1:UNIT_BITS];
        end
    end

    // stage 4: restore sign, output register
    t_ctl                  r_ctl4;
    logic [VALUE_BITS-1:0] r_forward;
    logic [VALUE_BITS-1:0] r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl4 <= '0;
        end else if (i_en) begin
            r_ctl4 <= r_ctl3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_forward <= i_step_length[VALUE_BITS-1] ? -r_fwd_mag : r_fwd_mag;
            r_height  <= i_step_height[VALUE_BITS-1] ? -r_hgt_mag : r_hgt_mag;
        end
    end

    assign o_ctl     = r_ctl4;
    assign o_forward = r_forward;
    assign o_height  = r_height;

endmodule

@@ design/swing_foot_poly_trajectory.sv @@
// Top level of the swing foot trajectory sampler: configuration registers,
// sample time stage, divider and shape pipeline. Depends on swfp_pkg,
// swfp_div and swfp_shape.
//
// Usage:
//   Slave channel: one transaction carries a sample index i in tdata.
//   Master channel: one transaction per sample, forward offset and height
//   offset (signed Q16.16) in tdata, swing flag in tuser.
//   Time t = i * sample_period; while t < swing_time the foot follows the
//   cubic forward and quartic vertical swing curves, else it rests at the
//   full step length with zero height.
//   The stages are time product, swing compare, 30 divider stages
//   (one quotient bit each) and four shape and scale stages.
//   Throughput is one sample per cycle; the whole pipeline advances as a
//   unit, so a stalled receiver holds every stage and s_tready drops only
//   while the output transaction waits.
//   Configuration writes take effect at once; write only while no sample
//   is in flight.
//   Reset empties the pipeline and loads sample_period = swing_time = 1.0,
//   step_length = step_height = 0.
`timescale 1ns / 1ps

module swing_foot_poly_trajectory
    import swfp_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [VALUE_BITS-1:0]  i_cfg_wdata,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [11:0] sample_index
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [31:0] forward_offset, [63:32] height_offset
    output logic                   m_tuser    // [0] in_swing
);

    logic [TIME_BITS-1:0]  r_sample_period;
    logic [TIME_BITS-1:0]  r_swing_time;
    logic [VALUE_BITS-1:0] r_step_length;
    logic [VALUE_BITS-1:0] r_step_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_period <= TIME_RESET;
            r_swing_time    <= TIME_RESET;
            r_step_length   <= '0;
            r_step_height   <= '0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_addr))
                REG_SAMPLE_PERIOD: r_sample_period <= i_cfg_wdata[TIME_BITS-1:0];
                REG_SWING_TIME:    r_swing_time    <= i_cfg_wdata[TIME_BITS-1:0];
                REG_STEP_LENGTH:   r_step_length   <= i_cfg_wdata;
                REG_STEP_HEIGHT:   r_step_height   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    logic en;
    t_ctl out_ctl;

    assign en       = ~out_ctl.valid | m_tready;
    assign s_tready = en;

    // stage 1: sample time
    t_ctl                 r_ctl1;
    logic [PROD_BITS-1:0] r_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
        end else if (en) begin
            r_ctl1 <= '{valid: s_tvalid, swing: 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t <= PROD_BITS'(s_tdata[INDEX_BITS-1:0]) * PROD_BITS'(r_sample_period);
        end
    end

    // stage 2: swing compare
    t_ctl                 r_ctl2;
    logic [TIME_BITS-1:0] r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl2 <= '0;
        end else if (en) begin
            r_ctl2 <= '{valid: r_ctl1.valid, swing: (r_t < PROD_BITS'(r_swing_time))};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rem <= r_t[TIME_BITS-1:0];
        end
    end

    t_ctl                 div_ctl;
    logic [UNIT_BITS-1:0] div_u;

    swfp_div u_div (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_swing_time (r_swing_time),
        .i_ctl        (r_ctl2),
        .i_rem        (r_rem),
        .o_ctl        (div_ctl),
        .o_quot       (div_u)
    );

    logic [VALUE_BITS-1:0] forward;
    logic [VALUE_BITS-1:0] height;

    swfp_shape u_shape (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (en),
        .i_step_length (r_step_length),
        .i_step_height (r_step_height),
        .i_ctl         (div_ctl),
        .i_u           (div_u),
        .o_ctl         (out_ctl),
        .o_forward     (forward),
        .o_height      (height)
    );

    assign m_tvalid = out_ctl.valid;
    assign m_tdata  = {height, forward};
    assign m_tuser  = out_ctl.swing;

endmodule

@@ verif/tb_top.sv @@
// Testbench of the swing foot trajectory sampler: a queue-fed stream driver,
// a result monitor that checks each sample against its own fixed-point
// prediction, and random idling on both sides. Depends on swfp_pkg and swing_foot_poly_trajectory.
`timescale 1ns / 1ps

module tb_top;
    import swfp_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 48;
    localparam int RANDOM_PHASES  = 20;

    typedef struct packed {
        logic [VALUE_BITS-1:0] forward;
        logic [VALUE_BITS-1:0] height;
        logic                  swing;
    } t_sample_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0]  i_cfg_addr = '0;
    logic [VALUE_BITS-1:0]  i_cfg_wdata = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;   // [11:0] sample_index
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;        // [31:0] forward_offset, [63:32] height_offset
    logic                   m_tuser;        // [0] in_swing

    logic [TIME_BITS-1:0]         period_reg;
    logic [TIME_BITS-1:0]         swing_reg;
    logic signed [VALUE_BITS-1:0] length_reg;
    logic signed [VALUE_BITS-1:0] height_reg;

    logic [INDEX_BITS-1:0] pending_indices[$];
    t_sample_result        expected_samples[$];
    int                    mismatch_count = 0;
    int                    quiet_cycles = 0;
    int                    send_idle = 0;
    int                    recv_stall = 0;
    bit                    send_burst = 1'b0;
    bit                    recv_burst = 1'b0;

    swing_foot_poly_trajectory uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_wdata(i_cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // value * shape / 2^30, toward zero, clamped to 32 bits
    function automatic logic [VALUE_BITS-1:0] scale_offset(
        input logic signed [VALUE_BITS-1:0] value, input logic [63:0] shape);
        logic signed [63:0] wide;
        logic signed [63:0] res;
        logic [63:0]        mag;
        logic [63:0]        prod;
        wide = value;
        mag  = (wide < 0) ? -wide : wide;
        prod = (mag * shape) >> UNIT_BITS;
        res  = (wide < 0) ? -$signed(prod) : $signed(prod);
        if (res > 64'sd2147483647) res = 64'sd2147483647;
        if (res < -64'sd2147483648) res = -64'sd2147483648;
        return res[VALUE_BITS-1:0];
    endfunction

    function automatic t_sample_result predict_sample(input logic [INDEX_BITS-1:0] idx);
        logic [63:0]    t;
        logic [63:0]    u;
        logic [63:0]    u2;
        logic [63:0]    fwd_shape;
        logic [63:0]    v;
        logic [63:0]    lift_shape;
        logic [63:0]    one;
        t_sample_result r;
        one = 64'd1 << UNIT_BITS;
        t   = 64'(idx) * 64'(period_reg);
        if (t < 64'(swing_reg)) begin
            u          = (t << UNIT_BITS) / 64'(swing_reg);
            u2         = (u * u) >> UNIT_BITS;
            fwd_shape  = (u2 * (3 * one - 2 * u)) >> UNIT_BITS;
            v          = (u * (one - u)) >> UNIT_BITS;
            lift_shape = (v * v) >> (UNIT_BITS - 4);
            r.forward  = scale_offset(length_reg, fwd_shape);
            r.height   = scale_offset(height_reg, lift_shape);
            r.swing    = 1'b1;
        end else begin
            r.forward = length_reg;
            r.height  = '0;
            r.swing   = 1'b0;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [VALUE_BITS-1:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= value;
        case (idx)
            REG_SAMPLE_PERIOD: period_reg = value[TIME_BITS-1:0];
            REG_SWING_TIME:    swing_reg  = value[TIME_BITS-1:0];
            REG_STEP_LENGTH:   length_reg = value;
            REG_STEP_HEIGHT:   height_reg = value;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // junk in the top bit of the time registers must be ignored
    task automatic configure(input logic [TIME_BITS-1:0] period, input logic [TIME_BITS-1:0] swing,
                             input logic [VALUE_BITS-1:0] len, input logic [VALUE_BITS-1:0] lift);
        write_reg(REG_SAMPLE_PERIOD, {1'($urandom), period});
        write_reg(REG_SWING_TIME, {1'($urandom), swing});
        write_reg(REG_STEP_LENGTH, len);
        write_reg(REG_STEP_HEIGHT, lift);
        @(negedge i_clk);
    endtask

    task automatic drain();
        while (pending_indices.size() != 0 || s_tvalid || expected_samples.size() != 0)
            @(negedge i_clk);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid  <= 1'b0;
            s_tdata   <= '0;
            send_idle = 0;
        end else begin
            if (s_tvalid && s_tready)
                expected_samples.push_back(predict_sample(s_tdata[INDEX_BITS-1:0]));
            if (!s_tvalid || s_tready) begin
                if (send_idle > 0) begin
                    send_idle--;
                    s_tvalid <= 1'b0;
                end else if (pending_indices.size() != 0) begin
                    s_tdata   <= IN_TDATA_W'(pending_indices.pop_front());
                    s_tvalid  <= 1'b1;
                    send_idle = send_burst ? 0 : pick_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_sample_result want;
        if (!i_rst_n) begin
            m_tready   <= 1'b0;
            recv_stall = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_samples.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %h user %b", m_tdata, m_tuser));
                end else begin
                    want = expected_samples.pop_front();
                    if (m_tdata[VALUE_BITS-1:0] !== want.forward)
                        report_mismatch($sformatf("forward_offset got %h expected %h",
                                                  m_tdata[VALUE_BITS-1:0], want.forward));
                    if (m_tdata[2*VALUE_BITS-1:VALUE_BITS] !== want.height)
                        report_mismatch($sformatf("height_offset got %h expected %h",
                                                  m_tdata[2*VALUE_BITS-1:VALUE_BITS],
                                                  want.height));
                    if (m_tuser !== want.swing)
                        report_mismatch($sformatf("in_swing got %b expected %b",
                                                  m_tuser, want.swing));
                end
            end
            if (recv_stall > 0) begin
                recv_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready   <= 1'b1;
                recv_stall = (m_tvalid && m_tready && !recv_burst) ? pick_gap() : 0;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || i_cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        logic [TIME_BITS-1:0]  swing;
        logic [TIME_BITS-1:0]  period;
        logic [VALUE_BITS-1:0] len;
        logic [VALUE_BITS-1:0] lift;
        int                    steps;
        int                    span;
        int                    count;
        int                    pick;

        period_reg = TIME_RESET;
        swing_reg  = TIME_RESET;
        length_reg = '0;
        height_reg = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset values
        pending_indices.push_back(12'd0);
        pending_indices.push_back(12'd1);
        pending_indices.push_back(12'd4095);
        drain();

        // sixteen samples per swing, extreme step values
        configure(31'h0000_1000, 31'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        pending_indices.push_back(12'd0);
        pending_indices.push_back(12'd1);
        pending_indices.push_back(12'd8);
        pending_indices.push_back(12'd15);
        pending_indices.push_back(12'd16);
        pending_indices.push_back(12'd17);
        pending_indices.push_back(12'd4095);
        drain();

        // zero sample period: always swing at t = 0
        configure(31'd0, 31'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        pending_indices.push_back(12'd0);
        pending_indices.push_back(12'd4095);
        pending_indices.push_back(12'd2048);
        drain();

        // zero swing time: always resting
        configure(31'd1, 31'd0, -32'sd12345, 32'd777);
        pending_indices.push_back(12'd0);
        pending_indices.push_back(12'd4095);
        drain();

        // widest time product
        configure(31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'd123456, -32'sd99999);
        pending_indices.push_back(12'd0);
        pending_indices.push_back(12'd1);
        pending_indices.push_back(12'd2);
        pending_indices.push_back(12'd4095);
        drain();

        configure(31'd1, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        pending_indices.push_back(12'd4095);
        pending_indices.push_back(12'd2048);
        pending_indices.push_back(12'd2730);
        pending_indices.push_back(12'd1365);
        drain();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            send_burst = ($urandom_range(0, 3) == 0);
            recv_burst = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 30)      swing = TIME_BITS'($urandom_range(1, 32'h0001_0000));
            else if (pick < 70) swing = TIME_BITS'($urandom_range(32'h0001_0000, 32'h0100_0000));
            else if (pick < 95) swing = TIME_BITS'($urandom_range(1, 32'h7FFF_FFFF));
            else                swing = ($urandom_range(0, 1) != 0) ? 31'h7FFF_FFFF : 31'd1;
            steps = $urandom_range(1, 4095);
            pick = $urandom_range(0, 99);
            if (pick < 60)      period = TIME_BITS'(swing / steps + $urandom_range(0, 3));
            else if (pick < 85) period = TIME_BITS'(swing / steps);
            else if (pick < 95) period = TIME_BITS'($urandom_range(0, 32'h7FFF_FFFF));
            else                period = ($urandom_range(0, 1) != 0) ? 31'h7FFF_FFFF : 31'd0;
            if (period != 0 && swing / period < 4095)
                steps = int'(swing / period);
            len  = ($urandom_range(0, 9) == 0) ? (($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF
                                                                             : 32'h8000_0000)
                                               : $urandom;
            lift = ($urandom_range(0, 9) == 0) ? (($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF
                                                                             : 32'h8000_0000)
                                               : $urandom;
            configure(period, swing, len, lift);
            span  = (steps + steps / 4 + 2 > 4095) ? 4095 : steps + steps / 4 + 2;
            count = $urandom_range(60, 104);
            for (int k = 0; k < count; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 60)
                    pending_indices.push_back(12'($urandom_range(0, span)));
                else if (pick < 70)
                    pending_indices.push_back(12'($urandom_range(steps < 2 ? 0 : steps - 2,
                                                                 steps > 4093 ? 4095 : steps + 2)));
                else
                    pending_indices.push_back(12'($urandom));
            end
            drain();
        end

        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ swing_foot_poly_trajectory.f @@
design/swfp_pkg.sv
design/swfp_div.sv
design/swfp_shape.sv
design/swing_foot_poly_trajectory.sv
verif/tb_top.sv
